// ===== rtl/erlang_b_blocking_and_dimensioning_assert.svh =====
// ----------------------------------------------------------------------------
// Erlang B assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ERLANG_B_BLOCKING_AND_DIMENSIONING_ASSERT_SVH
`define ERLANG_B_BLOCKING_AND_DIMENSIONING_ASSERT_SVH
`ifndef SYNTHESIS
// assertion checked only out of reset
`define EBD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assertion checked on every edge, reset included
`define EBD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EBD_ASSERT(name, clk, rst_n, prop, msg)
`define EBD_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ===== rtl/ebd_pkg.sv =====
// ----------------------------------------------------------------------------
// ebd_pkg
// Shared widths, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ebd_pkg;

    localparam int TRAFFIC_W      = 20;
    localparam int CIRC_W         = 10;
    localparam int PROB_FRAC_BITS = 24;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam int PROD_W         = TRAFFIC_W + PROB_W;
    localparam int STAT_W         = 2;
    localparam int MAX_CIRCUITS   = 1023;
    localparam int DIV_CNT_W      = $clog2(PROB_FRAC_BITS);

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd2;

    // request kinds
    localparam logic REQ_BLOCKING = 1'b0;
    localparam logic REQ_CIRCUITS = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic ld_item;   // capture item, check arguments, seed recursion
        logic mul;       // product A*B
        logic div_ld;    // form denominator, seed remainder
        logic div_step;  // one restoring division step
        logic upd;       // commit new blocking, advance circuit count
    } ebd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic arg_ok;    // arguments valid, recursion must run
        logic div_last;  // last division step this cycle
        logic fin;       // recursion ends with this update
    } ebd_sts_t;

endpackage

// ===== rtl/ebd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ebd_ctrl
// Sequencer for the Erlang B recursion: item accept, argument check, multiply, divide, update, result hand-off.
// ----------------------------------------------------------------------------
`include "erlang_b_blocking_and_dimensioning_assert.svh"

module ebd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_beat,    // input beat accepted
    input  logic             out_free,   // output register can take a result
    input  ebd_pkg::ebd_sts_t sts,
    output ebd_pkg::ebd_cmd_t cmd,
    output logic             in_ready,
    output logic             out_load
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        out_load     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    cmd.ld_item = 1'b1;
                    state_next  = S_CHK;
                end
            end
            S_CHK: begin
                state_next = sts.arg_ok ? S_MUL : S_DONE;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.div_ld = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                cmd.upd    = 1'b1;
                state_next = sts.fin ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `EBD_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> state_reg == S_IDLE, "reset must leave sequencer idle")
    `EBD_ASSERT(a_cmd_onehot, aclk, aresetn, $onehot0({cmd, out_load}), "more than one command at once")
    `EBD_ASSERT(a_accept_idle, aclk, aresetn, in_beat |-> state_reg == S_IDLE, "beat accepted while busy")

endmodule

// ===== rtl/ebd_dp.sv =====
// ----------------------------------------------------------------------------
// ebd_dp
// Datapath: item registers, A*B multiplier, restoring divider, result fields.
// ----------------------------------------------------------------------------
`include "erlang_b_blocking_and_dimensioning_assert.svh"

module ebd_dp #(
    parameter int MAX_CIRCUITS = ebd_pkg::MAX_CIRCUITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ebd_pkg::ebd_cmd_t             cmd,
    input  logic                          in_req_type,
    input  logic [ebd_pkg::TRAFFIC_W-1:0] in_traffic,
    input  logic [ebd_pkg::CIRC_W-1:0]    in_circuits,
    input  logic [ebd_pkg::PROB_W-1:0]    in_target_grade,
    output ebd_pkg::ebd_sts_t             sts,
    output logic [ebd_pkg::PROB_W-1:0]    res_blocking,
    output logic [ebd_pkg::CIRC_W-1:0]    res_circuits_needed,
    output logic [ebd_pkg::STAT_W-1:0]    res_status
);

    localparam int F     = ebd_pkg::PROB_FRAC_BITS;
    localparam int NW    = $clog2(MAX_CIRCUITS + 1);
    localparam int NSH_W = NW + F + 8;
    // denominator n*2^(F+8) + A*B, one bit of headroom for the sum
    localparam int DW    = ((NSH_W > ebd_pkg::PROD_W) ? NSH_W : ebd_pkg::PROD_W) + 1;
    localparam int CMP_W = ((NW > ebd_pkg::CIRC_W) ? NW : ebd_pkg::CIRC_W) + 1;
    localparam logic [NW-1:0] N_MAX = NW'(MAX_CIRCUITS);

    logic                          kind_reg;
    logic [ebd_pkg::TRAFFIC_W-1:0] t_reg;
    logic [ebd_pkg::PROB_W-1:0]    tg_reg;
    logic [NW-1:0]                 lim_reg;
    logic [ebd_pkg::STAT_W-1:0]    stat_reg;
    logic [ebd_pkg::PROB_W-1:0]    b_reg;
    logic [NW-1:0]                 n_reg;
    logic [ebd_pkg::PROD_W-1:0]    p_reg;
    logic [DW-1:0]                 den_reg;
    logic [DW-1:0]                 rem_reg, rem_next;
    logic [F-1:0]                  q_reg;
    logic [ebd_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic [ebd_pkg::STAT_W-1:0]    arg_stat;
    logic [DW:0]                   rem_sh;
    logic                          q_bit;
    logic                          step_last;
    logic                          grade_met;

    // argument check on the incoming beat
    always_comb begin
        arg_stat = ebd_pkg::STAT_OK;
        if (in_req_type == ebd_pkg::REQ_BLOCKING) begin
            if (in_circuits == '0) begin
                arg_stat = ebd_pkg::STAT_BAD;
            end else if (CMP_W'(in_circuits) > CMP_W'(N_MAX)) begin
                arg_stat = ebd_pkg::STAT_LIMIT;
            end
        end else begin
            if (in_target_grade == '0 || in_target_grade > ebd_pkg::PROB_ONE) begin
                arg_stat = ebd_pkg::STAT_BAD;
            end
        end
    end

    // restoring division step: shift, compare, subtract
    always_comb begin
        rem_sh   = {rem_reg, 1'b0};
        q_bit    = (rem_sh >= {1'b0, den_reg});
        rem_next = q_bit ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
    end

    // end of recursion tests: circuit limit reached, or grade met by the fresh quotient
    assign step_last = (n_reg == lim_reg);
    assign grade_met = (kind_reg == ebd_pkg::REQ_CIRCUITS) && ({1'b0, q_reg} <= tg_reg);

    assign sts.arg_ok   = (stat_reg == ebd_pkg::STAT_OK);
    assign sts.div_last = (cnt_reg == '0);
    assign sts.fin      = step_last || grade_met;

    // item capture and recursion state
    always_ff @(posedge aclk) begin
        if (cmd.ld_item) begin
            kind_reg <= in_req_type;
            t_reg    <= in_traffic;
            tg_reg   <= in_target_grade;
            lim_reg  <= (in_req_type == ebd_pkg::REQ_BLOCKING) ? NW'(in_circuits) : N_MAX;
            stat_reg <= arg_stat;
            b_reg    <= ebd_pkg::PROB_ONE;
            n_reg    <= NW'(1);
        end
        if (cmd.upd) begin
            b_reg <= {1'b0, q_reg};
            if (!sts.fin) begin
                n_reg <= n_reg + NW'(1);
            end else if (kind_reg == ebd_pkg::REQ_CIRCUITS && !grade_met) begin
                stat_reg <= ebd_pkg::STAT_LIMIT;
            end
        end
    end

    // multiplier A*B, registered before the divider
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            p_reg <= ebd_pkg::PROD_W'(t_reg) * ebd_pkg::PROD_W'(b_reg);
        end
    end

    // divider: remainder starts at A*B since the quotient is below one
    always_ff @(posedge aclk) begin
        if (cmd.div_ld) begin
            den_reg <= (DW'(n_reg) << (F + 8)) + DW'(p_reg);
            rem_reg <= DW'(p_reg);
            q_reg   <= '0;
            cnt_reg <= ebd_pkg::DIV_CNT_W'(F - 1);
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[F-2:0], q_bit};
            cnt_reg <= cnt_reg - ebd_pkg::DIV_CNT_W'(1);
        end
    end

    // result fields; the unused field of each kind reads zero
    always_comb begin
        res_status          = stat_reg;
        res_blocking        = '0;
        res_circuits_needed = '0;
        if (stat_reg == ebd_pkg::STAT_OK) begin
            if (kind_reg == ebd_pkg::REQ_BLOCKING) begin
                res_blocking = b_reg;
            end else begin
                res_circuits_needed = ebd_pkg::CIRC_W'(n_reg);
            end
        end
    end

    `EBD_ASSERT(a_rem_below_den, aclk, aresetn, cmd.div_step |-> rem_reg < den_reg, "remainder not below denominator")
    `EBD_ASSERT(a_n_in_range, aclk, aresetn, cmd.upd |-> (n_reg <= lim_reg && n_reg != '0), "circuit count out of range")
    `EBD_ASSERT(a_seed, aclk, aresetn, cmd.ld_item |=> (b_reg == ebd_pkg::PROB_ONE && n_reg == NW'(1)), "recursion not seeded")

endmodule

// ===== rtl/erlang_b_blocking_and_dimensioning.sv =====
// ----------------------------------------------------------------------------
// erlang_b_blocking_and_dimensioning
// Erlang B blocking probability and circuit dimensioning by exact recursion.
// ----------------------------------------------------------------------------
//  Channel  Dir  Bits (low to high)                                   Type
//  s_       in   tuser: req_type | tdata: traffic, circuits, target   stream
//  m_       out  tdata: blocking, circuits_needed, status             stream
//
//  One recursion step per circuit: one multiply, one denominator load,
//  PROB_FRAC_BITS radix-2 divider steps, one update. An item runs n steps,
//  n the circuits run (up to MAX_CIRCUITS); a bad argument skips the recursion.
//  Reset is synchronous and active low; no clearing pass.
//  One item in flight; the next beat is taken while the result waits in the
//  output register, and the block stalls only if that register is still full.
// ----------------------------------------------------------------------------
module erlang_b_blocking_and_dimensioning #(
    parameter int MAX_CIRCUITS = ebd_pkg::MAX_CIRCUITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // traffic[19:0], circuits[29:20], target_grade[54:30]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // blocking[24:0], circuits_needed[34:25], status[36:35]
);

    localparam int RES_W = ebd_pkg::PROB_W + ebd_pkg::CIRC_W + ebd_pkg::STAT_W;

    ebd_pkg::ebd_cmd_t              cmd;
    ebd_pkg::ebd_sts_t              sts;
    logic                           in_beat;
    logic                           out_free;
    logic                           out_load;
    logic [ebd_pkg::PROB_W-1:0]     res_blocking;
    logic [ebd_pkg::CIRC_W-1:0]     res_circuits_needed;
    logic [ebd_pkg::STAT_W-1:0]     res_status;
    logic                           out_valid_reg;
    logic [RES_W-1:0]               out_data_reg;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    ebd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (in_beat),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_tready),
        .out_load (out_load)
    );

    ebd_dp #(
        .MAX_CIRCUITS (MAX_CIRCUITS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .in_req_type         (s_tuser[0]),
        .in_traffic          (s_tdata[19:0]),
        .in_circuits         (s_tdata[29:20]),
        .in_target_grade     (s_tdata[54:30]),
        .sts                 (sts),
        .res_blocking        (res_blocking),
        .res_circuits_needed (res_circuits_needed),
        .res_status          (res_status)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {res_status, res_circuits_needed, res_blocking};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(40 - RES_W)'(0), out_data_reg};

endmodule
